// ===== design/ntcfd_pkg.sv =====
// Shared types and constants for the NTC fault detector.
package ntcfd_pkg;

    localparam int ADC_BITS     = 12;
    localparam int BLINK_PERIOD = 50;
    localparam int BLINK_BITS   = 6;
    localparam int PERSIST_BITS = 6;
    localparam int CFG_BITS     = 12;
    localparam int IDX_BITS     = 3;
    localparam int IN_BITS      = ((ADC_BITS + 2 + 7) / 8) * 8;
    localparam int OUT_BITS     = 8;

    localparam logic [BLINK_BITS-1:0] BLINK_LAST  = BLINK_BITS'(BLINK_PERIOD - 1);
    localparam logic [BLINK_BITS-1:0] BLINK_HALF  = BLINK_BITS'(BLINK_PERIOD / 2);

    typedef enum logic [IDX_BITS-1:0] {
        REG_SHORT_TH  = 3'd0,
        REG_DRY_TH    = 3'd1,
        REG_REC_LOW   = 3'd2,
        REG_OPEN_TH   = 3'd3,
        REG_REC_HIGH  = 3'd4,
        REG_PERSIST   = 3'd5
    } reg_idx_t;

    typedef enum logic [1:0] {
        FAULT_NONE  = 2'd0,
        FAULT_SHORT = 2'd1,
        FAULT_DRY   = 2'd2,
        FAULT_OPEN  = 2'd3
    } fault_code_t;

    typedef struct packed {
        logic [ADC_BITS-1:0]     short_th;
        logic [ADC_BITS-1:0]     dry_th;
        logic [ADC_BITS-1:0]     rec_low;
        logic [ADC_BITS-1:0]     open_th;
        logic [ADC_BITS-1:0]     rec_high;
        logic [PERSIST_BITS-1:0] persist_limit;
    } cfg_t;

    typedef struct packed {
        logic [ADC_BITS-1:0] adc_sample;
        logic                heating_active;
        logic                buzzer_busy;
    } req_t;

    typedef struct packed {
        logic        alarm_active;
        fault_code_t fault_code;
        logic        display_refresh;
        logic        display_blank;
        logic        shutdown_pulse;
        logic        recovered;
    } res_t;

endpackage

// ===== design/ntcfd_cfg.sv =====
// Configuration register file for the NTC fault detector.
module ntcfd_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [ntcfd_pkg::IDX_BITS-1:0]   cfg_index,
    input  logic [ntcfd_pkg::CFG_BITS-1:0]   cfg_data,
    output ntcfd_pkg::cfg_t                  cfg
);

    ntcfd_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.short_th      <= ntcfd_pkg::ADC_BITS'(80);
            cfg_reg.dry_th        <= ntcfd_pkg::ADC_BITS'(100);
            cfg_reg.rec_low       <= ntcfd_pkg::ADC_BITS'(709);
            cfg_reg.open_th       <= ntcfd_pkg::ADC_BITS'(3965);
            cfg_reg.rec_high      <= ntcfd_pkg::ADC_BITS'(3530);
            cfg_reg.persist_limit <= ntcfd_pkg::PERSIST_BITS'(25);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ntcfd_pkg::REG_SHORT_TH:
                    cfg_reg.short_th <= cfg_data[ntcfd_pkg::ADC_BITS-1:0];
                ntcfd_pkg::REG_DRY_TH:
                    cfg_reg.dry_th <= cfg_data[ntcfd_pkg::ADC_BITS-1:0];
                ntcfd_pkg::REG_REC_LOW:
                    cfg_reg.rec_low <= cfg_data[ntcfd_pkg::ADC_BITS-1:0];
                ntcfd_pkg::REG_OPEN_TH:
                    cfg_reg.open_th <= cfg_data[ntcfd_pkg::ADC_BITS-1:0];
                ntcfd_pkg::REG_REC_HIGH:
                    cfg_reg.rec_high <= cfg_data[ntcfd_pkg::ADC_BITS-1:0];
                ntcfd_pkg::REG_PERSIST:
                    cfg_reg.persist_limit <= cfg_data[ntcfd_pkg::PERSIST_BITS-1:0];
                default:
                    ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== design/ntcfd_core.sv =====
// Fault decision logic and detector state for the NTC fault detector.
module ntcfd_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  ntcfd_pkg::req_t  req,
    input  ntcfd_pkg::cfg_t  cfg,
    output ntcfd_pkg::res_t  res
);

    logic [ntcfd_pkg::BLINK_BITS-1:0]   blink_reg, blink_next;
    logic [ntcfd_pkg::PERSIST_BITS-1:0] persist_reg, persist_next;
    logic                               short_reg, short_next;
    logic                               dry_reg, dry_next;
    logic                               open_reg, open_next;
    logic                               alarm_reg, alarm_next;
    logic                               armed_reg, armed_next;

    logic [ntcfd_pkg::ADC_BITS-1:0]     s;
    logic [ntcfd_pkg::ADC_BITS-1:0]     short_band;
    logic [ntcfd_pkg::PERSIST_BITS:0]   cnt_inc;
    logic                               is_short, is_dry, is_open, hit, latch, in_band;

    assign s          = req.adc_sample;
    assign short_band = dry_reg ? cfg.dry_th : cfg.rec_low;
    assign is_short   = (s < cfg.short_th) || (short_reg && s < short_band);
    assign is_dry     = (req.heating_active && !alarm_reg && s < cfg.dry_th &&
                         s > cfg.short_th) ||
                        (dry_reg && s > cfg.short_th && s < cfg.rec_low);
    assign is_open    = (s > cfg.open_th) ||
                        (open_reg && s > cfg.rec_high && s < cfg.open_th);
    assign hit        = is_short || is_dry || is_open;
    assign cnt_inc    = {1'b0, persist_reg} + 1'b1;
    assign latch      = cnt_inc > {1'b0, cfg.persist_limit};
    assign in_band    = s > cfg.rec_low && s < cfg.rec_high;

    always_comb
    begin
        blink_next   = (blink_reg >= ntcfd_pkg::BLINK_LAST) ? '0 : blink_reg + 1'b1;
        persist_next = persist_reg;
        short_next   = short_reg;
        dry_next     = dry_reg;
        open_next    = open_reg;
        alarm_next   = alarm_reg;
        armed_next   = armed_reg;

        res.fault_code      = ntcfd_pkg::FAULT_NONE;
        res.display_refresh = 1'b0;
        res.shutdown_pulse  = 1'b0;
        res.recovered       = 1'b0;

        if (!req.buzzer_busy)
        begin
            if (hit)
            begin
                if (latch)
                begin
                    persist_next = '0;
                    if (is_short)
                    begin
                        short_next     = 1'b1;
                        res.fault_code = ntcfd_pkg::FAULT_SHORT;
                    end
                    else if (is_dry)
                    begin
                        dry_next       = 1'b1;
                        res.fault_code = ntcfd_pkg::FAULT_DRY;
                    end
                    else
                    begin
                        open_next      = 1'b1;
                        res.fault_code = ntcfd_pkg::FAULT_OPEN;
                    end
                    alarm_next          = 1'b1;
                    res.display_refresh = 1'b1;
                    if (armed_reg)
                    begin
                        armed_next         = 1'b0;
                        res.shutdown_pulse = 1'b1;
                    end
                end
                else
                begin
                    persist_next = cnt_inc[ntcfd_pkg::PERSIST_BITS-1:0];
                end
            end
            else if (alarm_reg && in_band)
            begin
                short_next    = 1'b0;
                dry_next      = 1'b0;
                open_next     = 1'b0;
                armed_next    = 1'b1;
                alarm_next    = 1'b0;
                res.recovered = 1'b1;
            end
        end

        res.alarm_active  = alarm_next;
        res.display_blank = blink_next >= ntcfd_pkg::BLINK_HALF;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blink_reg   <= '0;
            persist_reg <= '0;
            short_reg   <= 1'b0;
            dry_reg     <= 1'b0;
            open_reg    <= 1'b0;
            alarm_reg   <= 1'b0;
            armed_reg   <= 1'b1;
        end
        else if (advance)
        begin
            blink_reg   <= blink_next;
            persist_reg <= persist_next;
            short_reg   <= short_next;
            dry_reg     <= dry_next;
            open_reg    <= open_next;
            alarm_reg   <= alarm_next;
            armed_reg   <= armed_next;
        end
    end

    // armed for a shutdown exactly when no alarm is latched
    a_armed_alarm: assert property (@(posedge clk) disable iff (!rst_n)
        armed_reg != alarm_reg)
        else $error("shutdown arming out of step with alarm");

    a_refresh_alarm: assert property (@(posedge clk) disable iff (!rst_n)
        advance && res.display_refresh |=> alarm_reg)
        else $error("refresh without alarm latched");

    a_recover_clear: assert property (@(posedge clk) disable iff (!rst_n)
        advance && res.recovered |=> !alarm_reg && !short_reg && !dry_reg && !open_reg)
        else $error("recovery left a fault latched");

    a_busy_hold: assert property (@(posedge clk) disable iff (!rst_n)
        advance && req.buzzer_busy |=> $stable(persist_reg) && $stable(alarm_reg))
        else $error("state changed while buzzer busy");

    a_blink_range: assert property (@(posedge clk) disable iff (!rst_n)
        blink_reg <= ntcfd_pkg::BLINK_LAST)
        else $error("blink phase out of range");

endmodule

// ===== design/ntc_fault_detector.sv =====
// Top level of the NTC fault detector: request and result registers around the core.
//
//  channel | dir | tdata fields (lsb first)                          | handshake
//  s_      | in  | adc_sample[11:0], heating_active, buzzer_busy     | tvalid/tready
//  m_      | out | alarm, fault_code[1:0], refresh, blank, shut, rec | tvalid/tready
//  cfg_    | in  | cfg_index selects register, cfg_data value        | cfg_we
//
// One request a cycle while m_tready keeps up; a taken request passes the request register
// and then the result register before it leaves on m_.
// Reset clears the detector state (leaving it armed for shutdown) and loads the default thresholds.
// A stalled result holds in its register; one request waits behind it.
module ntc_fault_detector (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // adc_sample[11:0], heating_active[12], buzzer_busy[13], zero pad
    input  logic [ntcfd_pkg::IN_BITS-1:0]       s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // alarm_active[0], fault_code[2:1], display_refresh[3], display_blank[4],
    // shutdown_pulse[5], recovered[6], zero[7]
    output logic [ntcfd_pkg::OUT_BITS-1:0]      m_tdata,
    input  logic                                cfg_we,
    input  logic [ntcfd_pkg::IDX_BITS-1:0]      cfg_index,
    input  logic [ntcfd_pkg::CFG_BITS-1:0]      cfg_data
);

    ntcfd_pkg::cfg_t cfg;
    ntcfd_pkg::req_t req_reg;
    ntcfd_pkg::res_t res, res_reg;
    logic            req_vld_reg;
    logic            res_vld_reg;
    logic            out_free;
    logic            advance;

    assign out_free = !res_vld_reg || m_tready;
    assign advance  = req_vld_reg && out_free;
    assign s_tready = !req_vld_reg || advance;

    ntcfd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ntcfd_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .req     (req_reg),
        .cfg     (cfg),
        .res     (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_vld_reg <= 1'b0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                req_vld_reg <= s_tvalid;
            end
            if (out_free)
            begin
                res_vld_reg <= advance;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            req_reg.adc_sample     <= s_tdata[ntcfd_pkg::ADC_BITS-1:0];
            req_reg.heating_active <= s_tdata[ntcfd_pkg::ADC_BITS];
            req_reg.buzzer_busy    <= s_tdata[ntcfd_pkg::ADC_BITS+1];
        end
        if (advance)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = res_vld_reg;
    assign m_tdata  = {1'b0, res_reg.recovered, res_reg.shutdown_pulse,
                       res_reg.display_blank, res_reg.display_refresh,
                       res_reg.fault_code, res_reg.alarm_active};

endmodule
